@@ rtl/core/strongly_connected_components_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros for the component search block.
// These wrap concurrent assertions clocked on clock and disabled in reset.
// ------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define SCC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scc check failed");
// Checks that a condition implies a consequence in the same cycle.
`define SCC_ASSERT_IMP(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("scc implication failed");
`else
`define SCC_ASSERT(lbl, prop)
`define SCC_ASSERT_IMP(lbl, cond, cons)
`endif
`endif

@@ rtl/core/scc_pkg.sv @@
// ------------------------------------------------------------------------
// Component search package
// Shared constants, command codes and controller/datapath interfaces.
// ------------------------------------------------------------------------
package scc_pkg;
   localparam int MAX_NODES_DEF = 32;
   localparam int RESULT_CAP    = 32;
   localparam int NODE_W        = 5;
   localparam int CMD_W         = 2;
   localparam int CNT_W         = 6;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic add;
      logic start;
      logic enter_root;
      logic descend;
      logic skip;
      logic lowk_rd;
      logic lowk_upd;
      logic ret;
      logic pop_rd;
      logic pop_emit;
      logic frame_rd;
      logic parent_rd;
      logic parent_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic root_found;
      logic scan_found;
      logic k_visited;
      logic k_onstack;
      logic k_self;
      logic is_root;
      logic depth_zero;
      logic w_is_u;
      logic out_busy;
   } dp_status_type;
endpackage

@@ rtl/core/strongly_connected_components.sv @@
// Clear and add-edge requests give no result. A run scans each edge in turn, with a
// low-link read added when the neighbor is still on the stack; it tries roots, pops with
// a stack read and any wait for the result register to drain, and returns to a parent
// via frame read, parent read and parent load, since the stack and low-link RAMs read registered.
// Requests are taken only while idle; one run is in flight at a time.
// Reset is synchronous, empties the graph and sets node_count to 1.
// ------------------------------------------------------------------------
// Strongly connected components
// Loads a directed graph and finds its components depth first.
// ------------------------------------------------------------------------
module strongly_connected_components
   import scc_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [NODE_W-1:0]  req_src_node,
   input  logic [NODE_W-1:0]  req_dst_node,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [NODE_W-1:0]  rsp_node_index,
   output logic [NODE_W-1:0]  rsp_component_index,
   output logic               rsp_last_of_component,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data
);
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer.
   scc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // Graph storage and walk state.
   scc_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_src_node          (req_src_node),
      .req_dst_node          (req_dst_node),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_node_index        (rsp_node_index),
      .rsp_component_index   (rsp_component_index),
      .rsp_last_of_component (rsp_last_of_component),
      .rsp_last              (rsp_last)
   );
endmodule

@@ rtl/core/scc_ram.sv @@
// ------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ------------------------------------------------------------------------
module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/scc_ctrl.sv @@
// ------------------------------------------------------------------------
// Component search controller
// Sequences loading, the depth-first walk, component pops and returns.
// ------------------------------------------------------------------------
module scc_ctrl
   import scc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [CMD_W-1:0]   req_command,
   output logic               req_ready,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_ROOT  = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_LOWK  = 9'b000001000,
      S_POPRD = 9'b000010000,
      S_POPWT = 9'b000100000,
      S_AFTER = 9'b001000000,
      S_FRAME = 9'b010000000,
      S_PLOAD = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_command)
                  CMD_CLEAR: cmd.clear = 1'b1;
                  CMD_ADD:   cmd.add = 1'b1;
                  CMD_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = S_ROOT;
                  end
                  default: ;
               endcase
            end
         end
         S_ROOT: begin
            if (status.root_found) begin
               cmd.enter_root = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (status.scan_found) begin
               if (!status.k_visited) begin
                  cmd.descend = 1'b1;
               end else if (status.k_onstack && !status.k_self) begin
                  cmd.lowk_rd = 1'b1;
                  state_in    = S_LOWK;
               end else begin
                  cmd.skip = 1'b1;
               end
            end else begin
               cmd.ret  = 1'b1;
               state_in = status.is_root ? S_POPRD : S_AFTER;
            end
         end
         S_LOWK: begin
            cmd.lowk_upd = 1'b1;
            state_in     = S_SCAN;
         end
         S_POPRD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POPWT;
         end
         S_POPWT: begin
            if (!status.out_busy) begin
               cmd.pop_emit = 1'b1;
               state_in     = status.w_is_u ? S_AFTER : S_POPRD;
            end
         end
         S_AFTER: begin
            if (status.depth_zero) begin
               state_in = S_ROOT;
            end else begin
               cmd.frame_rd = 1'b1;
               state_in     = S_FRAME;
            end
         end
         S_FRAME: begin
            cmd.parent_rd = 1'b1;
            state_in      = S_PLOAD;
         end
         S_PLOAD: begin
            cmd.parent_load = 1'b1;
            state_in        = S_SCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/core/scc_dp.sv @@
// ------------------------------------------------------------------------
// Component search datapath
// Adjacency matrix, walk registers, stacks in RAM and the result register.
// ------------------------------------------------------------------------
`include "strongly_connected_components_macros.svh"
module scc_dp
   import scc_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic [NODE_W-1:0]  req_src_node,
   input  logic [NODE_W-1:0]  req_dst_node,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [NODE_W-1:0]  rsp_node_index,
   output logic [NODE_W-1:0]  rsp_component_index,
   output logic               rsp_last_of_component,
   output logic               rsp_last
);
   localparam int CAP   = (MAX_NODES < RESULT_CAP) ? MAX_NODES : RESULT_CAP;
   localparam int IDX_W = $clog2(CAP);
   localparam int KW    = $clog2(CAP + 1);
   localparam int FW    = IDX_W + KW;

   logic [CAP-1:0]   adj_ff [CAP];
   logic [CAP-1:0]   adj_in [CAP];
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic [CAP-1:0]   visited_ff, visited_in;
   logic [CAP-1:0]   onstack_ff, onstack_in;
   logic [IDX_W-1:0] cur_u_ff, cur_u_in;
   logic [KW-1:0]    cur_k_ff, cur_k_in;
   logic [IDX_W-1:0] cur_low_ff, cur_low_in;
   logic [IDX_W-1:0] cur_vis_ff, cur_vis_in;
   logic [IDX_W-1:0] child_low_ff, child_low_in;
   logic             upd_ff, upd_in;
   logic [KW-1:0]    depth_ff, depth_in;
   logic [KW-1:0]    sp_ff, sp_in;
   logic [KW-1:0]    vcnt_ff, vcnt_in;
   logic [KW-1:0]    comp_ff, comp_in;
   logic [KW-1:0]    popcnt_ff, popcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [NODE_W-1:0] rsp_comp_ff, rsp_comp_in;
   logic             rsp_loc_ff, rsp_loc_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [KW-1:0]    n_eff;
   logic             edge_ok;
   logic [CAP-1:0]   row_cur;
   logic             scan_found, root_found;
   logic [IDX_W-1:0] k_idx, root_idx, enter_v;
   logic [KW-1:0]    k_next, sp_dec, depth_dec;
   logic             enter;
   logic [IDX_W-1:0] low_rd, vis_rd, stk_rd, frame_node;
   logic [KW-1:0]    frame_next;
   logic [FW-1:0]    frame_rd_data;

   // Effective node count, capped at the storage size.
   assign n_eff = (node_count_ff > CNT_W'(CAP)) ? KW'(CAP) : KW'(node_count_ff);
   assign edge_ok = (CNT_W'(req_src_node) < CNT_W'(n_eff)) &&
                    (CNT_W'(req_dst_node) < CNT_W'(n_eff));

   // Lowest neighbor of the current node at or above the scan position.
   assign row_cur = adj_ff[cur_u_ff];
   always_comb begin
      scan_found = 1'b0;
      k_idx      = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (row_cur[i] && (KW'(i) >= cur_k_ff) && (KW'(i) < n_eff)) begin
            scan_found = 1'b1;
            k_idx      = IDX_W'(i);
         end
      end
   end

   // Lowest unvisited node for the next root.
   always_comb begin
      root_found = 1'b0;
      root_idx   = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (!visited_ff[i] && (KW'(i) < n_eff)) begin
            root_found = 1'b1;
            root_idx   = IDX_W'(i);
         end
      end
   end

   assign k_next    = KW'(k_idx) + 1'b1;
   assign sp_dec    = sp_ff - 1'b1;
   assign depth_dec = depth_ff - 1'b1;
   assign enter     = cmd.enter_root || cmd.descend;
   assign enter_v   = cmd.enter_root ? root_idx : k_idx;
   assign frame_node = frame_rd_data[FW-1:KW];
   assign frame_next = frame_rd_data[KW-1:0];

   // Low-link values, written when a node leaves the top of the call stack.
   scc_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_low_ram (
      .clock   (clock),
      .wr_en   (cmd.descend || cmd.ret),
      .wr_addr (cur_u_ff),
      .wr_data (cur_low_ff),
      .rd_en   (cmd.lowk_rd || cmd.parent_rd),
      .rd_addr (cmd.lowk_rd ? k_idx : frame_node),
      .rd_data (low_rd)
   );

   // Visit numbers, written on entry.
   scc_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_vis_ram (
      .clock   (clock),
      .wr_en   (enter),
      .wr_addr (enter_v),
      .wr_data (IDX_W'(vcnt_ff)),
      .rd_en   (cmd.parent_rd),
      .rd_addr (frame_node),
      .rd_data (vis_rd)
   );

   // Component stack of node indexes.
   scc_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_stk_ram (
      .clock   (clock),
      .wr_en   (enter),
      .wr_addr (sp_ff[IDX_W-1:0]),
      .wr_data (enter_v),
      .rd_en   (cmd.pop_rd),
      .rd_addr (sp_dec[IDX_W-1:0]),
      .rd_data (stk_rd)
   );

   // Call frames below the top, which lives in registers.
   scc_ram #(.WIDTH(FW), .DEPTH(CAP)) u_frm_ram (
      .clock   (clock),
      .wr_en   (cmd.descend),
      .wr_addr (depth_dec[IDX_W-1:0]),
      .wr_data ({cur_u_ff, k_next}),
      .rd_en   (cmd.frame_rd),
      .rd_addr (depth_dec[IDX_W-1:0]),
      .rd_data (frame_rd_data)
   );

   // Status to the controller.
   always_comb begin
      status.root_found = root_found;
      status.scan_found = scan_found;
      status.k_visited  = visited_ff[k_idx];
      status.k_onstack  = onstack_ff[k_idx];
      status.k_self     = (k_idx == cur_u_ff);
      status.is_root    = (cur_low_ff == cur_vis_ff);
      status.depth_zero = (depth_ff == '0);
      status.w_is_u     = (stk_rd == cur_u_ff);
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      adj_in        = adj_ff;
      node_count_in = node_count_ff;
      visited_in    = visited_ff;
      onstack_in    = onstack_ff;
      cur_u_in      = cur_u_ff;
      cur_k_in      = cur_k_ff;
      cur_low_in    = cur_low_ff;
      cur_vis_in    = cur_vis_ff;
      child_low_in  = child_low_ff;
      upd_in        = upd_ff;
      depth_in      = depth_ff;
      sp_in         = sp_ff;
      vcnt_in       = vcnt_ff;
      comp_in       = comp_ff;
      popcnt_in     = popcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end
      if (cmd.clear) begin
         for (int i = 0; i < CAP; i++) begin
            adj_in[i] = '0;
         end
      end
      if (cmd.add && edge_ok) begin
         adj_in[req_src_node[IDX_W-1:0]][req_dst_node[IDX_W-1:0]] = 1'b1;
      end
      if (cmd.start) begin
         visited_in = '0;
         onstack_in = '0;
         depth_in   = '0;
         sp_in      = '0;
         vcnt_in    = '0;
         comp_in    = '0;
         popcnt_in  = '0;
      end
      // Entering a node makes it the new top frame.
      if (enter) begin
         visited_in[enter_v] = 1'b1;
         onstack_in[enter_v] = 1'b1;
         cur_u_in   = enter_v;
         cur_k_in   = '0;
         cur_low_in = IDX_W'(vcnt_ff);
         cur_vis_in = IDX_W'(vcnt_ff);
         vcnt_in    = vcnt_ff + 1'b1;
         sp_in      = sp_ff + 1'b1;
         depth_in   = depth_ff + 1'b1;
      end
      if (cmd.skip || cmd.lowk_rd) begin
         cur_k_in = k_next;
      end
      if (cmd.lowk_upd && (low_rd < cur_low_ff)) begin
         cur_low_in = low_rd;
      end
      if (cmd.ret) begin
         depth_in     = depth_dec;
         upd_in       = !status.is_root;
         child_low_in = cur_low_ff;
      end
      if (cmd.pop_rd) begin
         sp_in = sp_dec;
      end
      // Result register drains whenever rsp_ready is high and loads on a pop.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.pop_emit) begin
         onstack_in[stk_rd] = 1'b0;
         popcnt_in    = popcnt_ff + 1'b1;
         if (status.w_is_u) begin
            comp_in = comp_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_node_in  = NODE_W'(stk_rd);
         rsp_comp_in  = NODE_W'(comp_ff);
         rsp_loc_in   = status.w_is_u;
         rsp_last_in  = ((popcnt_ff + 1'b1) == n_eff);
      end
      // Returning to a parent restores its frame and folds in the child.
      if (cmd.parent_load) begin
         cur_u_in   = frame_node;
         cur_k_in   = frame_next;
         cur_vis_in = vis_rd;
         cur_low_in = (upd_ff && (child_low_ff < low_rd)) ? child_low_ff : low_rd;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAP; i++) begin
            adj_ff[i] <= '0;
         end
         node_count_ff <= CNT_W'(1);
         visited_ff    <= '0;
         onstack_ff    <= '0;
         depth_ff      <= '0;
         sp_ff         <= '0;
         vcnt_ff       <= '0;
         comp_ff       <= '0;
         popcnt_ff     <= '0;
         upd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         adj_ff        <= adj_in;
         node_count_ff <= node_count_in;
         visited_ff    <= visited_in;
         onstack_ff    <= onstack_in;
         depth_ff      <= depth_in;
         sp_ff         <= sp_in;
         vcnt_ff       <= vcnt_in;
         comp_ff       <= comp_in;
         popcnt_ff     <= popcnt_in;
         upd_ff        <= upd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_u_ff     <= cur_u_in;
      cur_k_ff     <= cur_k_in;
      cur_low_ff   <= cur_low_in;
      cur_vis_ff   <= cur_vis_in;
      child_low_ff <= child_low_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_comp_ff  <= rsp_comp_in;
      rsp_loc_ff   <= rsp_loc_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_node_index        = rsp_node_ff;
   assign rsp_component_index   = rsp_comp_ff;
   assign rsp_last_of_component = rsp_loc_ff;
   assign rsp_last              = rsp_last_ff;

   // The call stack never holds more nodes than the component stack.
   `SCC_ASSERT(a_depth_le_sp, depth_ff <= sp_ff)
   // The component stack stays within its storage.
   `SCC_ASSERT(a_sp_bound, sp_ff <= KW'(CAP))
   // A pop is only emitted into a free result register.
   `SCC_ASSERT_IMP(a_emit_free, cmd.pop_emit, !(rsp_valid_ff && !rsp_ready))
endmodule

@@ bench/strongly_connected_components_test.sv @@
// ------------------------------------------------------------------------
// Component search testbench
// Loads random and directed graphs edge by edge, runs the depth-first
// component search and compares every emitted node with a local predictor.
// ------------------------------------------------------------------------
module strongly_connected_components_test;
   import scc_pkg::*;

   // One emitted node with its component information.
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] comp;
      logic              closes;
      logic              last;
   } member_type;

   // Scoreboard: keeps a copy of the graph and predicts component listings.
   class component_scoreboard;
      logic [31:0]       adj [32];
      logic [CNT_W-1:0]  count_reg;
      member_type        pending [$];
      int                errors;

      function void reset_state();
         foreach (adj[i]) adj[i] = '0;
         count_reg = CNT_W'(1);
         pending.delete();
         errors = 0;
      endfunction

      // Tarjan walk with explicit frames, successors in ascending order.
      function void search_components();
         int n, top, sp, visits, comps, produced, u, k, w;
         logic [31:0] seen, onstk;
         int vnum [32];
         int low [32];
         int stk [32];
         int fnode [32];
         int fnext [32];
         member_type m;
         n = (count_reg > 32) ? 32 : count_reg;
         seen = '0;
         onstk = '0;
         top = 0;
         sp = 0;
         visits = 0;
         comps = 0;
         produced = 0;
         for (int r = 0; r < n; r++) begin
            if (seen[r]) continue;
            vnum[r] = visits; low[r] = visits; visits++;
            seen[r] = 1'b1; onstk[r] = 1'b1; stk[sp++] = r;
            fnode[top] = r; fnext[top] = 0; top++;
            while (top > 0) begin
               u = fnode[top-1];
               k = fnext[top-1];
               while (k < n && !adj[u][k]) k++;
               if (k < n) begin
                  fnext[top-1] = k + 1;
                  if (!seen[k]) begin
                     vnum[k] = visits; low[k] = visits; visits++;
                     seen[k] = 1'b1; onstk[k] = 1'b1; stk[sp++] = k;
                     fnode[top] = k; fnext[top] = 0; top++;
                  end else if (onstk[k] && low[k] < low[u]) begin
                     low[u] = low[k];
                  end
                  continue;
               end
               top--;
               if (low[u] == vnum[u]) begin
                  while (sp > 0) begin
                     w = stk[--sp];
                     onstk[w] = 1'b0;
                     m.node = NODE_W'(w);
                     m.comp = NODE_W'(comps);
                     m.closes = (w == u);
                     m.last = 1'b0;
                     pending.insert(pending.size(), m);
                     produced++;
                     if (w == u) break;
                  end
                  comps++;
               end
               if (top > 0 && onstk[u] && low[u] < low[fnode[top-1]])
                  low[fnode[top-1]] = low[u];
            end
         end
         if (produced > 0) pending[pending.size()-1].last = 1'b1;
      endfunction

      // Notes an accepted request and updates the predicted state.
      function void note_request(logic [CMD_W-1:0] cmd, int s, int d);
         int n;
         n = (count_reg > 32) ? 32 : count_reg;
         case (cmd)
            CMD_CLEAR: begin
               foreach (adj[i]) adj[i] = '0;
            end
            CMD_ADD: begin
               if (s < n && d < n) adj[s][d] = 1'b1;
            end
            CMD_RUN: begin
               search_components();
            end
            default: ;
         endcase
      endfunction

      // Checks one accepted result against the oldest expectation.
      function void check_result(member_type got);
         member_type want;
         if (pending.size() == 0) begin
            $error("unexpected result node %0d", got.node);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.node !== got.node) begin
            $error("node_index expected %0d actual %0d", want.node, got.node);
            errors++;
         end
         if (want.comp !== got.comp) begin
            $error("component_index expected %0d actual %0d", want.comp, got.comp);
            errors++;
         end
         if (want.closes !== got.closes) begin
            $error("last_of_component expected %0d actual %0d", want.closes,
                   got.closes);
            errors++;
         end
         if (want.last !== got.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command = CMD_CLEAR;
   logic [NODE_W-1:0] req_src_node = '0;
   logic [NODE_W-1:0] req_dst_node = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [NODE_W-1:0] rsp_node_index;
   logic [NODE_W-1:0] rsp_component_index;
   logic              rsp_last_of_component;
   logic              rsp_last;
   logic              csr_wr_en = 0;
   logic [CNT_W-1:0]  csr_wr_data = '0;

   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                node_total = 1;
   component_scoreboard board;

   strongly_connected_components u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_src_node          (req_src_node),
      .req_dst_node          (req_dst_node),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_node_index        (rsp_node_index),
      .rsp_component_index   (rsp_component_index),
      .rsp_last_of_component (rsp_last_of_component),
      .rsp_last              (rsp_last),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Result side: random stalls, check on every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_node_index, rsp_component_index,
                             rsp_last_of_component, rsp_last});
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Sends one request, with optional idle cycles first. Valid stays high
   // after acceptance until the next request or an idle cycle replaces it.
   task automatic send_request(logic [CMD_W-1:0] cmd, int s, int d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_src_node <= NODE_W'(s);
      req_dst_node <= NODE_W'(d);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(cmd, s, d);
   endtask

   // Stops sending, waits for all results, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes the node count while the block is idle.
   task automatic set_node_count(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.count_reg = CNT_W'(value);
      node_total = (value > 32) ? 32 : value;
      @(posedge clock);
   endtask

   // A random graph: a clear, mostly in-range edges, a few random requests of any command and node, then a run.
   task automatic random_graph();
      int edges;
      send_request(CMD_CLEAR, $urandom_range(31), $urandom_range(31));
      edges = $urandom_range(node_total);
      for (int e = 0; e < edges; e++) begin
         if ($urandom_range(9) == 0)
            send_request(CMD_W'($urandom_range(3)), $urandom_range(31),
                         $urandom_range(31));
         else
            send_request(CMD_ADD, $urandom_range(node_total - 1),
                         $urandom_range(node_total - 1));
      end
      send_request(CMD_RUN, $urandom_range(31), $urandom_range(31));
   endtask

   initial begin
      board = new();
      board.reset_state();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default count, empty run, cycles, self loop, odd commands.
      send_request(CMD_RUN, 0, 0);
      set_node_count(0);
      send_request(CMD_ADD, 0, 0);
      send_request(CMD_RUN, 31, 31);
      set_node_count(32);
      send_request(CMD_ADD, 0, 31);
      send_request(CMD_ADD, 31, 0);
      send_request(CMD_ADD, 31, 0);
      send_request(CMD_ADD, 5, 5);
      send_request(CMD_ADD, 1, 2);
      send_request(CMD_ADD, 2, 1);
      send_request(CMD_UNUSED, 31, 31);
      send_request(CMD_RUN, 0, 0);
      set_node_count(4);
      send_request(CMD_ADD, 3, 4);
      send_request(CMD_ADD, 31, 3);
      send_request(CMD_RUN, 0, 0);
      set_node_count(63);
      send_request(CMD_RUN, 0, 0);
      send_request(CMD_CLEAR, 0, 0);
      send_request(CMD_RUN, 0, 0);

      // Random graphs across idling phases and node counts.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (int g = 0; g < 4; g++) begin
            set_node_count((g == 0) ? 32 : $urandom_range(2, 9));
            random_graph();
            if (g == 1) drain();
         end
      end
      drain();

      if (board.errors == 0)
         $display("strongly_connected_components_test OK");
      else
         $display("strongly_connected_components_test NOT OK");
      $finish;
   end

   // Timeout guard.
   initial begin
      #4000000;
      $display("strongly_connected_components_test NOT OK");
      $finish;
   end
endmodule
